// ===== hdl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int MAX_BLOCKS_DEF = 256;
   localparam int SIZE_W         = 26;
   localparam int IDX_W          = 16;

   localparam logic [31:0] HEAP_BASE_RESET  = 32'h0100_0000;
   localparam logic [26:0] HEAP_BYTES_RESET = 27'h400_0000;
   localparam logic [26:0] HEAP_BYTES_MAX   = 27'h400_0000;
   localparam int          HDR              = 32;
   localparam int          GRAIN            = 16;
   localparam int          GRAIN_MASK       = 15;
   localparam int          SPLIT_MIN        = HDR + GRAIN;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REALLOC = 2'd2;
   localparam logic [1:0] OP_STATS   = 2'd3;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_BYTES = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              used;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_ROTATE,
      CMD_SET,
      CMD_SPLIT,
      CMD_REMOVE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] index;
      entry_type        data;
      entry_type        data2;
   } cell_cmd_type;

endpackage

// ===== hdl/ffa_cell.sv =====
// ----------------------------------------------------------------------------
// ffa_cell
// One entry of the block table; takes a neighbor's entry on rotate, insert
// and remove commands.
// ----------------------------------------------------------------------------
module ffa_cell #(
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  ffa_pkg::cell_cmd_type cmd,
   input  ffa_pkg::entry_type   left,
   input  ffa_pkg::entry_type   right,
   output ffa_pkg::entry_type   entry
);
   import ffa_pkg::*;

   localparam logic [IDX_W:0] MY_IDX = (IDX_W+1)'(IDX);

   entry_type        entry_ff, entry_in;
   logic [IDX_W:0]   tgt;

   assign tgt = {1'b0, cmd.index};

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.kind)
         CMD_HOLD:   entry_in = entry_ff;
         CMD_ROTATE: entry_in = right;
         CMD_SET: begin
            if (MY_IDX == tgt) entry_in = cmd.data;
         end
         CMD_SPLIT: begin
            if (MY_IDX == tgt) entry_in = cmd.data;
            else if (MY_IDX == tgt + 1'b1) entry_in = cmd.data2;
            else if (MY_IDX > tgt + 1'b1) entry_in = left;
         end
         CMD_REMOVE: begin
            if (MY_IDX >= tgt) entry_in = right;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with split and coalesce over a ring of table cells.
// ----------------------------------------------------------------------------
// One item at a time; busy is high while it is worked on. A pass over the
// table rotates the ring of MAX_BLOCKS cells once, with cell 0 read each
// cycle, and ends in an apply step. Stats, free and a realloc that keeps or
// cannot find its block take one pass; alloc one pass, preceded by a setup
// step while the heap is not yet set up; a realloc that has to move takes two
// passes when no block fits and three when it moves. A merge then removes
// the merged entries in a remove step each. A free with address 0, and a
// free, stats or realloc with a nonzero address before the heap is set up,
// take no pass and busy stays low. The result appears on the rsp_ ports for
// one cycle with rsp_valid, in the cycle after the last busy cycle (or after
// the accepting edge), and must be taken then: the receiver cannot stall.
module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_block_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_address,
   output logic        rsp_granted,
   output logic [26:0] rsp_used_total,
   output logic [26:0] rsp_free_total,
   output logic [26:0] rsp_largest_free,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import ffa_pkg::*;

   localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_SCAN, ST_APPLY, ST_REMOVE} state_type;
   typedef enum logic [1:0] {PH_ALLOC, PH_FREE, PH_FIND, PH_STATS} phase_type;

   state_type   state_ff;
   phase_type   phase_ff;
   logic        realloc_ff;
   logic [31:0] heap_base_ff;
   logic [26:0] heap_bytes_ff;
   logic [CW-1:0] count_ff;
   logic        started_ff;
   logic [31:0] addr_ff;
   logic [32:0] need_ff;
   logic [CW-1:0] j_ff;
   logic [31:0] off_ff;
   // first fit
   logic        hit_ff;
   logic [IW-1:0] fit_idx_ff;
   logic [SIZE_W-1:0] fit_sz_ff;
   logic [31:0] fit_addr_ff;
   // address match and merge range
   logic        mhit_ff;
   logic        run_ff;
   logic [IW-1:0] lo_ff;
   logic [CW-1:0] rm_ff;
   logic [SIZE_W-1:0] msum_ff;
   logic [SIZE_W-1:0] k_sz_ff;
   logic        prev_used_ff;
   logic [SIZE_W-1:0] prev_sz_ff;
   // stats
   logic [26:0] used_sum_ff, free_sum_ff;
   logic [SIZE_W-1:0] big_ff;
   // granted address carried across realloc passes
   logic [31:0] res_addr_ff;
   logic        res_ok_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_addr_ff;
   logic        rsp_ok_ff;
   logic [26:0] rsp_used_ff, rsp_free_ff, rsp_big_ff;

   entry_type    cells [MAX_BLOCKS];
   cell_cmd_type cmd;
   entry_type    head;

   logic [32:0]  need_calc;
   logic [26:0]  hb_clamp;
   logic [SIZE_W-1:0] setup_sz;
   logic         in_range;
   logic         addr_match;
   logic         fits;
   logic         do_split;
   logic [SIZE_W-1:0] split_rest;
   logic         scan_last;

   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      ffa_cell #(.IDX(g)) u_cell (
         .clock (clock),
         .cmd   (cmd),
         .left  (cells[(g + MAX_BLOCKS - 1) % MAX_BLOCKS]),
         .right (cells[(g + 1) % MAX_BLOCKS]),
         .entry (cells[g])
      );
   end

   assign head = cells[0];

   always_comb begin
      need_calc = ({1'b0, req_request_size} + 33'(GRAIN_MASK)) & ~33'(GRAIN_MASK);
      if (need_calc < 33'(GRAIN)) need_calc = 33'(GRAIN);
   end

   always_comb begin
      hb_clamp = (heap_bytes_ff > HEAP_BYTES_MAX) ? HEAP_BYTES_MAX : heap_bytes_ff;
      setup_sz = '0;
      if (hb_clamp >= 27'(SPLIT_MIN))
         setup_sz = SIZE_W'((hb_clamp - 27'(HDR)) & ~27'(GRAIN_MASK));
   end

   assign in_range   = (j_ff < count_ff);
   assign addr_match = ((off_ff + 32'(HDR)) == addr_ff);
   assign fits       = !head.used && ({7'b0, head.size} >= need_ff);
   assign scan_last  = (j_ff == CW'(MAX_BLOCKS - 1));
   assign do_split   = ({8'b0, fit_sz_ff} >= ({1'b0, need_ff} + 34'(SPLIT_MIN)))
                       && (count_ff < CW'(MAX_BLOCKS));
   assign split_rest = fit_sz_ff - need_ff[SIZE_W-1:0] - SIZE_W'(HDR);

   always_comb begin
      cmd       = '0;
      cmd.kind  = CMD_HOLD;
      unique case (state_ff)
         ST_SETUP: begin
            cmd.kind = CMD_SET;
            cmd.data = '{size: setup_sz, used: 1'b0};
         end
         ST_SCAN: cmd.kind = CMD_ROTATE;
         ST_APPLY: begin
            if (phase_ff == PH_ALLOC && hit_ff) begin
               cmd.index = IDX_W'(fit_idx_ff);
               if (do_split) begin
                  cmd.kind  = CMD_SPLIT;
                  cmd.data  = '{size: need_ff[SIZE_W-1:0], used: 1'b1};
                  cmd.data2 = '{size: split_rest, used: 1'b0};
               end else begin
                  cmd.kind = CMD_SET;
                  cmd.data = '{size: fit_sz_ff, used: 1'b1};
               end
            end else if (phase_ff == PH_FREE && mhit_ff) begin
               cmd.kind  = CMD_SET;
               cmd.index = IDX_W'(lo_ff);
               cmd.data  = '{size: msum_ff, used: 1'b0};
            end
         end
         ST_REMOVE: begin
            cmd.kind  = CMD_REMOVE;
            cmd.index = IDX_W'(lo_ff) + 1'b1;
         end
         default: cmd.kind = CMD_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_ALLOC;
         realloc_ff    <= 1'b0;
         heap_base_ff  <= HEAP_BASE_RESET;
         heap_bytes_ff <= HEAP_BYTES_RESET;
         count_ff      <= '0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEAP_BASE:  heap_base_ff  <= csr_wdata;
               CSR_HEAP_BYTES: heap_bytes_ff <= csr_wdata[26:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  addr_ff     <= req_block_address;
                  need_ff     <= need_calc;
                  res_addr_ff <= '0;
                  res_ok_ff   <= 1'b0;
                  realloc_ff  <= 1'b0;
                  rsp_addr_ff <= '0;
                  rsp_ok_ff   <= 1'b0;
                  rsp_used_ff <= '0;
                  rsp_free_ff <= '0;
                  rsp_big_ff  <= '0;
                  phase_ff    <= PH_ALLOC;
                  state_ff    <= ST_SCAN;
                  if (req_operation == OP_ALLOC ||
                      (req_operation == OP_REALLOC && req_block_address == '0)) begin
                     if (!started_ff) state_ff <= ST_SETUP;
                  end else if (req_operation == OP_FREE ||
                               (req_operation == OP_REALLOC && req_request_size == '0)) begin
                     phase_ff <= PH_FREE;
                     if (req_block_address == '0 || !started_ff) begin
                        state_ff     <= ST_IDLE;
                        rsp_valid_ff <= 1'b1;
                     end
                  end else begin
                     phase_ff <= (req_operation == OP_STATS) ? PH_STATS : PH_FIND;
                     if (!started_ff) begin
                        state_ff     <= ST_IDLE;
                        rsp_valid_ff <= 1'b1;
                     end
                  end
                  j_ff        <= '0;
                  off_ff      <= heap_base_ff;
                  hit_ff      <= 1'b0;
                  mhit_ff     <= 1'b0;
                  run_ff      <= 1'b0;
                  used_sum_ff <= '0;
                  free_sum_ff <= '0;
                  big_ff      <= '0;
               end
            end

            ST_SETUP: begin
               count_ff   <= CW'(1);
               started_ff <= 1'b1;
               off_ff     <= heap_base_ff;
               state_ff   <= ST_SCAN;
            end

            ST_SCAN: begin
               if (in_range) begin
                  off_ff <= off_ff + 32'(HDR) + {6'b0, head.size};
                  if (!hit_ff && fits) begin
                     hit_ff      <= 1'b1;
                     fit_idx_ff  <= IW'(j_ff);
                     fit_sz_ff   <= head.size;
                     fit_addr_ff <= off_ff + 32'(HDR);
                  end
                  if (!mhit_ff && addr_match) begin
                     mhit_ff <= 1'b1;
                     run_ff  <= 1'b1;
                     k_sz_ff <= head.size;
                     // merge with a free block just below
                     if (j_ff != '0 && !prev_used_ff) begin
                        lo_ff   <= IW'(j_ff - 1'b1);
                        msum_ff <= prev_sz_ff + SIZE_W'(HDR) + head.size;
                        rm_ff   <= CW'(1);
                     end else begin
                        lo_ff   <= IW'(j_ff);
                        msum_ff <= head.size;
                        rm_ff   <= '0;
                     end
                  end else if (run_ff) begin
                     if (!head.used) begin
                        msum_ff <= msum_ff + SIZE_W'(HDR) + head.size;
                        rm_ff   <= rm_ff + 1'b1;
                     end else begin
                        run_ff <= 1'b0;
                     end
                  end
                  if (head.used) begin
                     used_sum_ff <= used_sum_ff + 27'(HDR) + {1'b0, head.size};
                  end else begin
                     free_sum_ff <= free_sum_ff + 27'(HDR) + {1'b0, head.size};
                     if (head.size > big_ff) big_ff <= head.size;
                  end
                  prev_used_ff <= head.used;
                  prev_sz_ff   <= head.size;
               end
               j_ff <= j_ff + 1'b1;
               if (scan_last) state_ff <= ST_APPLY;
            end

            ST_APPLY: begin
               state_ff <= ST_IDLE;
               j_ff     <= '0;
               off_ff   <= heap_base_ff;
               hit_ff   <= 1'b0;
               mhit_ff  <= 1'b0;
               run_ff   <= 1'b0;
               unique case (phase_ff)
                  PH_ALLOC: begin
                     if (hit_ff) begin
                        if (do_split) count_ff <= count_ff + 1'b1;
                        if (realloc_ff) begin
                           // old block is freed in a further pass
                           res_addr_ff <= fit_addr_ff;
                           res_ok_ff   <= 1'b1;
                           phase_ff    <= PH_FREE;
                           state_ff    <= ST_SCAN;
                        end else begin
                           rsp_addr_ff  <= fit_addr_ff;
                           rsp_ok_ff    <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end
                     end else begin
                        rsp_valid_ff <= 1'b1;
                     end
                  end
                  PH_FREE: begin
                     rsp_addr_ff <= res_addr_ff;
                     rsp_ok_ff   <= res_ok_ff;
                     if (mhit_ff && rm_ff != '0) state_ff <= ST_REMOVE;
                     else rsp_valid_ff <= 1'b1;
                  end
                  PH_FIND: begin
                     if (mhit_ff && ({7'b0, k_sz_ff} >= need_ff)) begin
                        rsp_addr_ff  <= addr_ff;
                        rsp_ok_ff    <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end else if (mhit_ff) begin
                        realloc_ff <= 1'b1;
                        phase_ff   <= PH_ALLOC;
                        state_ff   <= ST_SCAN;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                     end
                  end
                  PH_STATS: begin
                     rsp_used_ff  <= used_sum_ff;
                     rsp_free_ff  <= free_sum_ff;
                     rsp_big_ff   <= {1'b0, big_ff};
                     rsp_valid_ff <= 1'b1;
                  end
                  default: rsp_valid_ff <= 1'b1;
               endcase
               used_sum_ff <= '0;
               free_sum_ff <= '0;
               big_ff      <= '0;
            end

            ST_REMOVE: begin
               count_ff <= count_ff - 1'b1;
               rm_ff    <= rm_ff - 1'b1;
               if (rm_ff == CW'(1)) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_granted        = rsp_ok_ff;
   assign rsp_used_total     = rsp_used_ff;
   assign rsp_free_total     = rsp_free_ff;
   assign rsp_largest_free   = rsp_big_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("block count beyond table depth");

   a_empty_before_setup: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> count_ff == '0)
      else $error("table has entries before setup");

   a_grant_no_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_used_total == '0 && rsp_free_total == '0)
      else $error("stats fields set on a granted item");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_operation == OP_STATS && started_ff |=> busy)
      else $error("stats item on a set-up heap did not start a pass");

endmodule
